// File: src/smh_pkg.sv
// shared types, constants and register map for the stepper move and home block
package smh_pkg;

    // default sizes of the step counter and the carried fraction
    localparam int STEP_COUNT_BITS = 24;
    localparam int FRAC_BITS       = 16;

    // field widths
    localparam int DIST_W    = 26;
    localparam int SPM_W     = 32;
    localparam int HP_W      = 16;
    localparam int TICK_W    = 24;
    localparam int HOME_W    = 24;
    localparam int PROD_W    = DIST_W + SPM_W;
    localparam int SPM_FRAC  = 16;
    localparam int DIST_FRAC = 16;

    // register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_STEPS_PER_MM = 2'd0;
    localparam logic [1:0] REG_INVERT_DIR   = 2'd1;
    localparam logic [1:0] REG_HOME_PAUSE   = 2'd2;

    // reset value of the pause register, 200 ms of microsecond ticks
    localparam logic [TICK_W-1:0] HOME_PAUSE_RESET = 24'd200000;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_HOME = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_MOVE_HI = 3'd1,
        PH_MOVE_LO = 3'd2,
        PH_HOME_HI = 3'd3,
        PH_HOME_LO = 3'd4,
        PH_PAUSE   = 3'd5,
        PH_RET_HI  = 3'd6,
        PH_RET_LO  = 3'd7
    } phase_t;

    typedef struct packed {
        op_t               op;
        logic [DIST_W-1:0] distance_mm_q16;
        logic              forward;
        logic [HP_W-1:0]   half_period_us;
        logic              clear_fraction;
        logic              endstop_level;
    } item_t;

    typedef struct packed {
        logic [HOME_W-1:0] home_steps;
        logic              param_error;
        logic              done_res;
        logic              busy_res;
        logic              enable_n;
        logic              dir_level;
        logic              step_level;
    } result_t;

    typedef struct packed {
        logic [SPM_W-1:0]  steps_per_mm_q16;
        logic              invert_direction;
        logic [TICK_W-1:0] home_pause_ticks;
    } cfg_t;

endpackage

// File: src/smh_seq.sv
// move and homing sequencer: state registers and the per-word update
module smh_seq #(
    parameter int STEP_COUNT_BITS = smh_pkg::STEP_COUNT_BITS,
    parameter int FRAC_BITS       = smh_pkg::FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step_en,
    input  smh_pkg::item_t            item,
    input  logic [smh_pkg::PROD_W-1:0] prod,
    input  smh_pkg::cfg_t             cfg,
    output smh_pkg::result_t          res
);

    localparam int TOT_W    = smh_pkg::PROD_W + 1;
    localparam int PROD_SHR = smh_pkg::SPM_FRAC + smh_pkg::DIST_FRAC - FRAC_BITS;
    localparam int TICK_W   = smh_pkg::TICK_W;

    smh_pkg::phase_t phase_reg, phase_next;
    logic [TICK_W-1:0]          tick_count_reg, tick_count_next;
    logic [STEP_COUNT_BITS-1:0] steps_left_reg, steps_left_next;
    logic [STEP_COUNT_BITS-1:0] homed_count_reg, homed_count_next;
    logic [FRAC_BITS-1:0]       fraction_carry_reg, fraction_carry_next;
    logic [smh_pkg::HP_W-1:0]   half_period_reg, half_period_next;
    logic                       dir_reg, dir_next;

    logic [smh_pkg::HP_W-1:0]   hp_in;
    logic [TICK_W-1:0]          tick_inc;
    logic                       half_done;
    logic                       pause_done;
    logic [FRAC_BITS-1:0]       carry_base;
    logic [TOT_W-1:0]           total;
    logic                       whole_over;
    logic [STEP_COUNT_BITS-1:0] whole;
    logic [STEP_COUNT_BITS-1:0] steps_dec;
    logic                       done;
    logic                       perr;
    logic [31:0]                homed_ext;

    // shared terms
    assign hp_in      = (item.half_period_us == '0) ? smh_pkg::HP_W'(1) : item.half_period_us;
    assign tick_inc   = tick_count_reg + TICK_W'(1);
    assign half_done  = tick_inc >= TICK_W'(half_period_reg);
    assign pause_done = tick_inc >= cfg.home_pause_ticks;
    assign carry_base = item.clear_fraction ? '0 : fraction_carry_reg;
    assign total      = TOT_W'(prod >> PROD_SHR) + TOT_W'(carry_base);
    assign whole_over = |total[TOT_W-1:FRAC_BITS+STEP_COUNT_BITS];
    assign whole      = whole_over ? '1 : total[FRAC_BITS+STEP_COUNT_BITS-1:FRAC_BITS];
    assign steps_dec  = (steps_left_reg != '0) ? steps_left_reg - STEP_COUNT_BITS'(1)
                                               : steps_left_reg;

    // next state
    always_comb
    begin
        phase_next          = phase_reg;
        tick_count_next     = tick_count_reg;
        steps_left_next     = steps_left_reg;
        homed_count_next    = homed_count_reg;
        fraction_carry_next = fraction_carry_reg;
        half_period_next    = half_period_reg;
        dir_next            = dir_reg;
        done                = 1'b0;
        perr                = 1'b0;

        if (phase_reg == smh_pkg::PH_IDLE && item.op == smh_pkg::OP_MOVE)
        begin
            fraction_carry_next = carry_base;
            if (cfg.steps_per_mm_q16 == '0)
            begin
                perr = 1'b1;
            end
            else
            begin
                fraction_carry_next = total[FRAC_BITS-1:0];
                dir_next            = item.forward ^ cfg.invert_direction;
                half_period_next    = hp_in;
                tick_count_next     = '0;
                steps_left_next     = whole;
                if (whole == '0)
                    done = 1'b1;
                else
                    phase_next = smh_pkg::PH_MOVE_HI;
            end
        end
        else if (phase_reg == smh_pkg::PH_IDLE && item.op == smh_pkg::OP_HOME)
        begin
            dir_next         = cfg.invert_direction;
            half_period_next = hp_in;
            tick_count_next  = '0;
            if (item.endstop_level)
            begin
                homed_count_next = STEP_COUNT_BITS'(1);
                phase_next       = smh_pkg::PH_HOME_HI;
            end
            else
            begin
                homed_count_next = '0;
                phase_next       = smh_pkg::PH_PAUSE;
            end
        end
        else
        begin
            unique case (phase_reg)
                smh_pkg::PH_IDLE:
                begin
                end
                smh_pkg::PH_MOVE_HI, smh_pkg::PH_RET_HI, smh_pkg::PH_HOME_HI:
                begin
                    tick_count_next = half_done ? '0 : tick_inc;
                    if (half_done)
                        phase_next = smh_pkg::phase_t'(phase_reg + 3'd1);
                end
                smh_pkg::PH_MOVE_LO, smh_pkg::PH_RET_LO:
                begin
                    tick_count_next = half_done ? '0 : tick_inc;
                    if (half_done)
                    begin
                        steps_left_next = steps_dec;
                        if (steps_dec == '0)
                        begin
                            phase_next = smh_pkg::PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            phase_next = smh_pkg::phase_t'(phase_reg - 3'd1);
                        end
                    end
                end
                smh_pkg::PH_HOME_LO:
                begin
                    tick_count_next = half_done ? '0 : tick_inc;
                    if (half_done)
                    begin
                        if (item.endstop_level)
                        begin
                            if (homed_count_reg != '1)
                                homed_count_next = homed_count_reg + STEP_COUNT_BITS'(1);
                            phase_next = smh_pkg::PH_HOME_HI;
                        end
                        else
                        begin
                            phase_next = smh_pkg::PH_PAUSE;
                        end
                    end
                end
                smh_pkg::PH_PAUSE:
                begin
                    tick_count_next = pause_done ? '0 : tick_inc;
                    if (pause_done)
                    begin
                        dir_next        = ~cfg.invert_direction;
                        steps_left_next = homed_count_reg;
                        if (homed_count_reg == '0)
                        begin
                            phase_next = smh_pkg::PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            phase_next = smh_pkg::PH_RET_HI;
                        end
                    end
                end
            endcase
        end
    end

    // state registers, advanced once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= smh_pkg::PH_IDLE;
            tick_count_reg     <= '0;
            steps_left_reg     <= '0;
            homed_count_reg    <= '0;
            fraction_carry_reg <= '0;
            half_period_reg    <= '0;
            dir_reg            <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg          <= phase_next;
            tick_count_reg     <= tick_count_next;
            steps_left_reg     <= steps_left_next;
            homed_count_reg    <= homed_count_next;
            fraction_carry_reg <= fraction_carry_next;
            half_period_reg    <= half_period_next;
            dir_reg            <= dir_next;
        end
    end

    // result levels after this word
    assign homed_ext = 32'(homed_count_next);

    always_comb
    begin
        res.step_level  = (phase_next == smh_pkg::PH_MOVE_HI) ||
                          (phase_next == smh_pkg::PH_HOME_HI) ||
                          (phase_next == smh_pkg::PH_RET_HI);
        res.dir_level   = dir_next;
        res.busy_res    = (phase_next != smh_pkg::PH_IDLE);
        res.enable_n    = (phase_next == smh_pkg::PH_IDLE);
        res.done_res    = done;
        res.param_error = perr;
        res.home_steps  = homed_ext[smh_pkg::HOME_W-1:0];
    end

`ifndef SYNTHESIS
    // a rejected move leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && perr) |=> (phase_reg == smh_pkg::PH_IDLE))
        else $error("rejected move left the sequencer busy");

    // a finished sequence always returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && done) |=> (phase_reg == smh_pkg::PH_IDLE))
        else $error("sequence flagged done but still running");

    // step phases keep their half period count in range
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != smh_pkg::PH_IDLE && phase_reg != smh_pkg::PH_PAUSE) |->
        (tick_count_reg < TICK_W'(half_period_reg)))
        else $error("half period counter overran");

    // moves and returns never run with no steps left
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == smh_pkg::PH_MOVE_HI || phase_reg == smh_pkg::PH_MOVE_LO ||
         phase_reg == smh_pkg::PH_RET_HI || phase_reg == smh_pkg::PH_RET_LO) |->
        (steps_left_reg != '0))
        else $error("stepping with zero steps left");
`endif

endmodule

// File: src/stepper_move_and_home.sv
// stepper move and home: stream ports, register port, word pipeline
//
//  channel  | direction | words
//  s_*      | in        | tick, move or home command, op in s_tuser
//  m_*      | out       | pin levels and status, one per input word
//  apb      | in/out    | steps per mm, direction invert, home pause
//
// one word per clock when the output is taken
// the distance product is registered with the word in the input register,
// and the carry add and sequencer update are registered into the output register
// an output stall holds one word in the input register before s_tready drops
// reset clears the sequencer to idle and the registers to their defaults
module stepper_move_and_home #(
    parameter int STEP_COUNT_BITS = smh_pkg::STEP_COUNT_BITS,
    parameter int FRAC_BITS       = smh_pkg::FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [25:0] distance_mm_q16, [26] forward, [42:27] half_period_us,
    // [43] clear_fraction, [44] endstop_level, [47:45] zero
    input  logic [47:0]                    s_tdata,
    // [1:0] op
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] step_level, [1] dir_level, [2] enable_n, [3] busy_res,
    // [4] done_res, [5] param_error, [29:6] home_steps, [31:30] zero
    output logic [31:0]                    m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [smh_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [smh_pkg::APB_DATA_W-1:0] pwdata,
    output logic [smh_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    smh_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    smh_pkg::item_t   item_reg;
    logic [smh_pkg::PROD_W-1:0] prod_reg;
    logic             out_valid_reg;
    smh_pkg::result_t out_reg;

    smh_pkg::item_t   item_in;
    smh_pkg::result_t res;
    logic             adv;
    logic             s_fire;
    logic             cfg_wr;
    logic [1:0]       reg_idx;

    // register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steps_per_mm_q16 <= '0;
            cfg_reg.invert_direction <= 1'b0;
            cfg_reg.home_pause_ticks <= smh_pkg::HOME_PAUSE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                smh_pkg::REG_STEPS_PER_MM: cfg_reg.steps_per_mm_q16 <= pwdata;
                smh_pkg::REG_INVERT_DIR:   cfg_reg.invert_direction <= pwdata[0];
                smh_pkg::REG_HOME_PAUSE:
                    cfg_reg.home_pause_ticks <= pwdata[smh_pkg::TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (reg_idx)
            smh_pkg::REG_STEPS_PER_MM: prdata = cfg_reg.steps_per_mm_q16;
            smh_pkg::REG_INVERT_DIR:   prdata = 32'(cfg_reg.invert_direction);
            smh_pkg::REG_HOME_PAUSE:   prdata = 32'(cfg_reg.home_pause_ticks);
            default:                   prdata = '0;
        endcase
    end

    // unpack the input word
    always_comb
    begin
        item_in.op              = smh_pkg::op_t'(s_tuser);
        item_in.distance_mm_q16 = s_tdata[25:0];
        item_in.forward         = s_tdata[26];
        item_in.half_period_us  = s_tdata[42:27];
        item_in.clear_fraction  = s_tdata[43];
        item_in.endstop_level   = s_tdata[44];
    end

    // handshake: the input register drains whenever the output can take a word
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
                in_valid_reg <= 1'b1;
            else if (adv)
                in_valid_reg <= 1'b0;

            if (adv)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // input register with the distance times calibration product
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg <= item_in;
            prod_reg <= smh_pkg::PROD_W'(item_in.distance_mm_q16) *
                        smh_pkg::PROD_W'(cfg_reg.steps_per_mm_q16);
        end
    end

    smh_seq #(
        .STEP_COUNT_BITS(STEP_COUNT_BITS),
        .FRAC_BITS      (FRAC_BITS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step_en(adv),
        .item   (item_reg),
        .prod   (prod_reg),
        .cfg    (cfg_reg),
        .res    (res)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.home_steps, out_reg.param_error, out_reg.done_res,
                       out_reg.busy_res, out_reg.enable_n, out_reg.dir_level,
                       out_reg.step_level};

`ifndef SYNTHESIS
    // input only stalls when both stages hold words and the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    // a stalled output word holds steady until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output word changed while stalled");

    // an output word only appears behind a held input word
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("output word appeared with no input word");
`endif

endmodule

// File: tb/stepper_move_and_home_tb.sv
// testbench for the stepper move and home block: stream words checked against a step predictor
`timescale 1ns / 1ps

module stepper_move_and_home_tb;

    localparam int         CYCLE_LIMIT = 600000;
    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam logic [smh_pkg::HOME_W-1:0] COUNT_MAX = {smh_pkg::HOME_W{1'b1}};

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [47:0]                    s_tdata  = '0;
    logic [1:0]                     s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [31:0]                    m_tdata;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [smh_pkg::APB_ADDR_W-1:0] paddr    = '0;
    logic [smh_pkg::APB_DATA_W-1:0] pwdata   = '0;
    logic [smh_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    stepper_move_and_home u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run length guard
    int cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // predicted register contents
    logic [smh_pkg::SPM_W-1:0]  cfg_spm   = '0;
    logic                       cfg_inv   = 1'b0;
    logic [smh_pkg::TICK_W-1:0] cfg_pause = smh_pkg::HOME_PAUSE_RESET;

    // predicted sequencer state
    smh_pkg::phase_t               seq_phase  = smh_pkg::PH_IDLE;
    logic [smh_pkg::TICK_W-1:0]    tick_cnt   = '0;
    logic [smh_pkg::HOME_W-1:0]    steps_rem  = '0;
    logic [smh_pkg::HOME_W-1:0]    home_cnt   = '0;
    logic [smh_pkg::FRAC_BITS-1:0] frac_carry = '0;
    logic [smh_pkg::HP_W-1:0]      half_per   = '0;
    logic                          dir_lat    = 1'b0;

    smh_pkg::result_t expected_words[$];
    int      mismatches     = 0;
    int      words_seen     = 0;
    int      send_gap_max   = 13;
    int      recv_stall_max = 13;
    int      hold_cycles    = 0;
    int      home_goal      = 0;

    task automatic count_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    // one half period of the step pin has run out
    function automatic bit half_elapsed();
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= {{(smh_pkg::TICK_W-smh_pkg::HP_W){1'b0}}, half_per})
        begin
            tick_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // one time base tick of the sequencer, high when a sequence ends
    function automatic bit advance_tick(input logic endstop);
        case (seq_phase)
            smh_pkg::PH_MOVE_HI, smh_pkg::PH_RET_HI, smh_pkg::PH_HOME_HI:
            begin
                if (half_elapsed())
                    seq_phase = smh_pkg::phase_t'(seq_phase + 3'd1);
            end
            smh_pkg::PH_MOVE_LO, smh_pkg::PH_RET_LO:
            begin
                if (half_elapsed())
                begin
                    if (steps_rem != '0)
                        steps_rem = steps_rem - 1'b1;
                    if (steps_rem == '0)
                    begin
                        seq_phase = smh_pkg::PH_IDLE;
                        return 1'b1;
                    end
                    seq_phase = smh_pkg::phase_t'(seq_phase - 3'd1);
                end
            end
            smh_pkg::PH_HOME_LO:
            begin
                if (half_elapsed())
                begin
                    if (endstop)
                    begin
                        if (home_cnt < COUNT_MAX)
                            home_cnt = home_cnt + 1'b1;
                        seq_phase = smh_pkg::PH_HOME_HI;
                    end
                    else
                        seq_phase = smh_pkg::PH_PAUSE;
                end
            end
            smh_pkg::PH_PAUSE:
            begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= cfg_pause)
                begin
                    tick_cnt  = '0;
                    dir_lat   = ~cfg_inv;
                    steps_rem = home_cnt;
                    if (steps_rem == '0)
                    begin
                        seq_phase = smh_pkg::PH_IDLE;
                        return 1'b1;
                    end
                    seq_phase = smh_pkg::PH_RET_HI;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // pin levels and status after one input word
    function automatic smh_pkg::result_t predict_word(input smh_pkg::item_t it);
        logic [smh_pkg::HP_W-1:0]                                  hp;
        logic [smh_pkg::PROD_W-1:0]                                prod;
        logic [smh_pkg::PROD_W-smh_pkg::SPM_FRAC:0]                total;
        logic [smh_pkg::PROD_W-smh_pkg::SPM_FRAC-smh_pkg::FRAC_BITS:0] whole;
        bit                                                        done;
        bit                                                        perr;
        smh_pkg::result_t                                          r;
        done = 1'b0;
        perr = 1'b0;
        hp   = (it.half_period_us == '0) ? smh_pkg::HP_W'(1) : it.half_period_us;
        if (seq_phase == smh_pkg::PH_IDLE && it.op == smh_pkg::OP_MOVE)
        begin
            if (it.clear_fraction)
                frac_carry = '0;
            if (cfg_spm == '0)
                perr = 1'b1;
            else
            begin
                // distance times calibration, fraction truncated, carry added
                prod       = it.distance_mm_q16 * cfg_spm;
                total      = prod[smh_pkg::PROD_W-1:smh_pkg::SPM_FRAC] + frac_carry;
                whole      = total >> smh_pkg::FRAC_BITS;
                frac_carry = total[smh_pkg::FRAC_BITS-1:0];
                dir_lat    = it.forward ^ cfg_inv;
                half_per   = hp;
                tick_cnt   = '0;
                steps_rem  = (whole > COUNT_MAX) ? COUNT_MAX : whole[smh_pkg::HOME_W-1:0];
                if (steps_rem == '0)
                    done = 1'b1;
                else
                    seq_phase = smh_pkg::PH_MOVE_HI;
            end
        end
        else if (seq_phase == smh_pkg::PH_IDLE && it.op == smh_pkg::OP_HOME)
        begin
            dir_lat  = cfg_inv;
            half_per = hp;
            tick_cnt = '0;
            if (it.endstop_level)
            begin
                home_cnt  = smh_pkg::HOME_W'(1);
                seq_phase = smh_pkg::PH_HOME_HI;
            end
            else
            begin
                home_cnt  = '0;
                seq_phase = smh_pkg::PH_PAUSE;
            end
        end
        else
            done = advance_tick(it.endstop_level);

        r.step_level  = (seq_phase == smh_pkg::PH_MOVE_HI || seq_phase == smh_pkg::PH_HOME_HI ||
                         seq_phase == smh_pkg::PH_RET_HI);
        r.dir_level   = dir_lat;
        r.busy_res    = (seq_phase != smh_pkg::PH_IDLE);
        r.enable_n    = ~r.busy_res;
        r.done_res    = done;
        r.param_error = perr;
        r.home_steps  = home_cnt;
        return r;
    endfunction

    // compare one output word with the oldest prediction
    task automatic check_word(input logic [31:0] word);
        smh_pkg::result_t want;
        smh_pkg::result_t got;
        got = smh_pkg::result_t'(word[29:0]);
        words_seen++;
        if (expected_words.size() == 0)
            count_mismatch($sformatf("word %0d arrived with nothing expected: %h",
                                     words_seen, word));
        else
        begin
            want = expected_words.pop_front();
            if (got.step_level !== want.step_level || got.dir_level !== want.dir_level ||
                got.enable_n !== want.enable_n || got.busy_res !== want.busy_res ||
                got.done_res !== want.done_res || got.param_error !== want.param_error ||
                got.home_steps !== want.home_steps || word[31:30] !== 2'b00)
                count_mismatch({
                    $sformatf("word %0d: exp step %b dir %b en_n %b busy %b done %b ",
                              words_seen, want.step_level, want.dir_level,
                              want.enable_n, want.busy_res, want.done_res),
                    $sformatf("perr %b home %0d, ", want.param_error, want.home_steps),
                    $sformatf("got step %b dir %b en_n %b busy %b done %b ",
                              got.step_level, got.dir_level, got.enable_n,
                              got.busy_res, got.done_res),
                    $sformatf("perr %b home %0d pad %b", got.param_error,
                              got.home_steps, word[31:30])});
        end
    endtask

    // output side: random stalls, or a long hold-off when requested
    initial
    begin : result_monitor
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            else if ($urandom_range(0, 3) == 0)
                stall = 0;
            else
                stall = $urandom_range(0, recv_stall_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            check_word(m_tdata);
        end
    end

    // register access: setup phase, access phase, then the bus returns to idle
    task automatic apb_access(input bit is_write, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] reg_value(input logic [1:0] idx);
        case (idx)
            smh_pkg::REG_STEPS_PER_MM: return cfg_spm;
            smh_pkg::REG_INVERT_DIR:   return {31'd0, cfg_inv};
            default:                   return {8'd0, cfg_pause};
        endcase
    endfunction

    task automatic check_reg(input logic [1:0] idx);
        logic [31:0] rd;
        apb_access(1'b0, idx, 32'd0, rd);
        if (rd !== reg_value(idx))
            count_mismatch($sformatf("register %0d read %h, exp %h", idx, rd,
                                     reg_value(idx)));
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        apb_access(1'b1, idx, val, rd);
        case (idx)
            smh_pkg::REG_STEPS_PER_MM: cfg_spm   = val;
            smh_pkg::REG_INVERT_DIR:   cfg_inv   = val[0];
            default:                   cfg_pause = val[smh_pkg::TICK_W-1:0];
        endcase
        check_reg(idx);
    endtask

    // offer one word after a random gap, predict it once taken
    task automatic send_word(input smh_pkg::item_t it);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {3'b000, it.endstop_level, it.clear_fraction, it.half_period_us,
                     it.forward, it.distance_mm_q16};
        do @(posedge clk); while (s_tready !== 1'b1);
        expected_words.push_back(predict_word(it));
    endtask

    // stop offering and wait for every predicted word
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    function automatic smh_pkg::item_t rand_fields();
        smh_pkg::item_t it;
        it.op              = smh_pkg::OP_TICK;
        it.distance_mm_q16 = smh_pkg::DIST_W'($urandom_range(0, 26'h3FF_FFFF));
        it.forward         = 1'($urandom_range(0, 1));
        it.half_period_us  = smh_pkg::HP_W'($urandom_range(0, 16'hFFFF));
        it.clear_fraction  = 1'($urandom_range(0, 1));
        it.endstop_level   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic smh_pkg::item_t make_move(input logic [smh_pkg::DIST_W-1:0] distance,
                                                 input logic fwd,
                                                 input logic [smh_pkg::HP_W-1:0] hp,
                                                 input logic clr);
        smh_pkg::item_t it;
        it                 = rand_fields();
        it.op              = smh_pkg::OP_MOVE;
        it.distance_mm_q16 = distance;
        it.forward         = fwd;
        it.half_period_us  = hp;
        it.clear_fraction  = clr;
        return it;
    endfunction

    function automatic smh_pkg::item_t make_home(input logic [smh_pkg::HP_W-1:0] hp,
                                                 input logic endstop);
        smh_pkg::item_t it;
        it                = rand_fields();
        it.op             = smh_pkg::OP_HOME;
        it.half_period_us = hp;
        it.endstop_level  = endstop;
        return it;
    endfunction

    task automatic send_ticks(input int n);
        repeat (n) send_word(rand_fields());
    endtask

    // ticks until the sequence ends; the endstop opens after goal steps
    task automatic tick_until_idle(input int goal);
        smh_pkg::item_t it;
        int             n;
        n = 0;
        while (seq_phase != smh_pkg::PH_IDLE && n < 50000)
        begin
            it = rand_fields();
            if (seq_phase == smh_pkg::PH_HOME_HI || seq_phase == smh_pkg::PH_HOME_LO)
                it.endstop_level = (home_cnt < goal);
            send_word(it);
            n++;
        end
    endtask

    // reset values, idle ticks and a move with no calibration
    task automatic test_reset_values();
        check_reg(smh_pkg::REG_STEPS_PER_MM);
        check_reg(smh_pkg::REG_INVERT_DIR);
        check_reg(smh_pkg::REG_HOME_PAUSE);
        send_ticks(2);
        send_word(make_move(26'h001_0000, 1'b1, 16'd1, 1'b1));
        send_ticks(2);
        wait_drained();
    endtask

    // step counts, carried fraction, zero steps and calibration extremes
    task automatic test_move_basics();
        set_reg(smh_pkg::REG_STEPS_PER_MM, 32'h0001_8000);
        set_reg(smh_pkg::REG_INVERT_DIR, 32'd0);
        send_word(make_move(26'h001_0000, 1'b1, 16'd0, 1'b1));
        tick_until_idle(0);
        send_word(make_move(26'h001_0000, 1'b0, 16'd2, 1'b0));
        tick_until_idle(0);
        send_word(make_move(26'h000_8000, 1'b1, 16'd1, 1'b1));
        send_ticks(1);
        wait_drained();
        set_reg(smh_pkg::REG_STEPS_PER_MM, 32'd1);
        send_word(make_move(26'h3FF_FFFF, 1'b1, 16'd1, 1'b1));
        send_ticks(1);
        wait_drained();
        set_reg(smh_pkg::REG_STEPS_PER_MM, 32'hFFFF_FFFF);
        send_word(make_move(26'd1, 1'b1, 16'd1, 1'b1));
        send_word(make_move(26'd1, 1'b0, 16'd3, 1'b0));
        tick_until_idle(0);
        wait_drained();
    endtask

    // inverted direction pin, commands while busy, spare op code
    task automatic test_direction_invert();
        smh_pkg::item_t it;
        set_reg(smh_pkg::REG_STEPS_PER_MM, 32'h0001_0000);
        set_reg(smh_pkg::REG_INVERT_DIR, 32'd1);
        send_word(make_move(26'h002_0000, 1'b1, 16'd1, 1'b1));
        send_word(make_home(16'd1, 1'b1));
        send_word(make_move(26'h3FF_FFFF, 1'b0, 16'hFFFF, 1'b1));
        it    = rand_fields();
        it.op = smh_pkg::op_t'(OP_SPARE);
        send_word(it);
        tick_until_idle(0);
        send_word(make_move(26'h002_0000, 1'b0, 16'd2, 1'b0));
        tick_until_idle(0);
        send_word(it);
        wait_drained();
    endtask

    // homing: endstop already reached, counted search, zero pause
    task automatic test_homing();
        set_reg(smh_pkg::REG_INVERT_DIR, 32'd0);
        set_reg(smh_pkg::REG_HOME_PAUSE, 32'd3);
        send_word(make_home(16'd1, 1'b0));
        tick_until_idle(0);
        send_word(make_home(16'd1, 1'b1));
        tick_until_idle(4);
        wait_drained();
        set_reg(smh_pkg::REG_HOME_PAUSE, 32'd0);
        set_reg(smh_pkg::REG_INVERT_DIR, 32'd1);
        send_word(make_home(16'd0, 1'b1));
        tick_until_idle(2);
        wait_drained();
    endtask

    // pause length is read live: longest pause cut short mid-wait
    task automatic test_live_pause();
        set_reg(smh_pkg::REG_HOME_PAUSE, 32'h00FF_FFFF);
        send_word(make_home(16'd2, 1'b0));
        send_ticks(5);
        wait_drained();
        set_reg(smh_pkg::REG_HOME_PAUSE, 32'd2);
        tick_until_idle(0);
        wait_drained();
    endtask

    // long output hold-off with the input pushing, then a full drain
    task automatic test_backpressure();
        set_reg(smh_pkg::REG_STEPS_PER_MM, 32'h0002_0000);
        send_gap_max = 0;
        hold_cycles  = 300;
        send_word(make_move(26'h003_0000, 1'b1, 16'd1, 1'b1));
        send_ticks(60);
        wait_drained();
        send_gap_max = 13;
        tick_until_idle(0);
        wait_drained();
    endtask

    // random traffic in phases, each with its own register settings
    task automatic test_random_traffic();
        smh_pkg::item_t it;
        int             pick;
        for (int p = 0; p < 6; p++)
        begin
            wait_drained();
            send_gap_max   = (p == 3) ? 0 : 13;
            recv_stall_max = (p == 3) ? 0 : 13;
            set_reg(smh_pkg::REG_STEPS_PER_MM,
                    (p == 2) ? 32'd0 : $urandom_range(32'h8000, 32'h6_0000));
            set_reg(smh_pkg::REG_INVERT_DIR, 32'(p % 2));
            set_reg(smh_pkg::REG_HOME_PAUSE, $urandom_range(0, 20));
            for (int i = 0; i < 210; i++)
            begin
                it = rand_fields();
                if (seq_phase == smh_pkg::PH_IDLE)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick <= 3)
                        it = make_move(smh_pkg::DIST_W'($urandom_range(0, 26'h003_0000)),
                                       1'($urandom_range(0, 1)),
                                       smh_pkg::HP_W'($urandom_range(0, 3)),
                                       1'($urandom_range(0, 1)));
                    else if (pick <= 5)
                    begin
                        it        = make_home(smh_pkg::HP_W'($urandom_range(0, 3)),
                                              $urandom_range(0, 4) != 0);
                        home_goal = $urandom_range(1, 10);
                    end
                    else if (pick == 6)
                        it.op = smh_pkg::op_t'(OP_SPARE);
                end
                else
                begin
                    // mostly ticks; stray commands are ignored while busy
                    pick = $urandom_range(0, 15);
                    if (pick == 0)
                        it.op = smh_pkg::op_t'($urandom_range(1, 2));
                    else if (pick == 1)
                        it.op = smh_pkg::op_t'(OP_SPARE);
                    if (seq_phase == smh_pkg::PH_HOME_HI || seq_phase == smh_pkg::PH_HOME_LO)
                        it.endstop_level = (home_cnt < home_goal) ^
                                           ($urandom_range(0, 19) == 0);
                end
                send_word(it);
            end
        end
        send_gap_max   = 13;
        recv_stall_max = 13;
        tick_until_idle(0);
        wait_drained();
    endtask

    // saturated step count with the longest half period; never finishes
    task automatic test_saturated_move();
        set_reg(smh_pkg::REG_STEPS_PER_MM, 32'hFFFF_FFFF);
        set_reg(smh_pkg::REG_INVERT_DIR, 32'd0);
        send_word(make_move(26'h3FF_FFFF, 1'b1, 16'hFFFF, 1'b1));
        send_ticks(40);
        wait_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_move_basics();
        test_direction_invert();
        test_homing();
        test_live_pause();
        test_backpressure();
        test_random_traffic();
        test_saturated_move();
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
src/smh_pkg.sv
src/smh_seq.sv
src/stepper_move_and_home.sv
tb/stepper_move_and_home_tb.sv
